### rtl/assert_macros.svh
// Assertion macros shared by the scan line unpacker RTL.
// No dependencies; files that check their own logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: forbidden condition seen");
`define ASSERT_IMPLY(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed: implication violated");
`else
`define ASSERT_NEVER(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, cond, prop)
`endif
`endif

### rtl/zsu_pkg.sv
// Shared constants, codes and types of the ZPixmap scan line unpacker.
// No dependencies; used by every module of the block.
package zsu_pkg;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  localparam int WIDTH_MAX      = 4096;
  localparam int HEIGHT_MAX     = 4096;
  localparam int LINE_BYTES_MAX = 131072;

  localparam int DEPTH_W    = 6;
  localparam int SIZE_W     = 13;
  localparam int LB_W       = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam int COL_W = $clog2(WIDTH_MAX + 1);
  localparam int ROW_W = $clog2(HEIGHT_MAX + 1);
  localparam int LBC_W = $clog2(LINE_BYTES_MAX + 1);
  localparam int LEN_W = imax(imax(LB_W, $clog2(4 * WIDTH_MAX + 1)), LBC_W) + 1;

  localparam int RES_MAX = 3;
  localparam int RCNT_W  = $clog2(RES_MAX + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_DEPTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_MSB_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_MSB     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES     = 3'd5;

  localparam logic [1:0] ST_PIXEL      = 2'd0;
  localparam logic [1:0] ST_BAD_DEPTH  = 2'd1;
  localparam logic [1:0] ST_SHORT_LINE = 2'd2;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
    logic        last_line;
    logic        last_image;
  } res_t;

  // All results caused by one accepted byte, in delivery order.
  typedef struct packed {
    logic [RCNT_W-1:0]       cnt;
    res_t [RES_MAX-1:0]      res;
  } rec_t;

endpackage

### rtl/zsu_front.sv
// Front end: configuration registers, line and pixel tracking, and the
// classification of each byte into its results. Depends on zsu_pkg.
module zsu_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [zsu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [zsu_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     data_byte,
  output logic                           push,
  output zsu_pkg::rec_t                  push_rec,
  input  logic                           push_ready
);
  import zsu_pkg::*;

  logic [DEPTH_W-1:0] pixel_depth;
  logic               data_msb_first;
  logic               header_msb;
  logic [SIZE_W-1:0]  image_width;
  logic [SIZE_W-1:0]  image_height;
  logic [LB_W-1:0]    line_bytes;

  logic [23:0]        partial_pixel;
  logic [1:0]         byte_in_pixel;
  logic [COL_W-1:0]   pixel_column;
  logic [LBC_W-1:0]   line_byte_count;
  logic [ROW_W-1:0]   row_count;

  logic [23:0]        partial_pixel_next;
  logic [1:0]         byte_in_pixel_next;
  logic [COL_W-1:0]   pixel_column_next;
  logic [LBC_W-1:0]   line_byte_count_next;
  logic [ROW_W-1:0]   row_count_next;

  logic               is4;
  logic               bad_depth;
  logic [1:0]         nbm1;
  logic [31:0]        mask;
  logic [COL_W-1:0]   wc;
  logic [ROW_W-1:0]   hc;
  logic [LEN_W-1:0]   wl;
  logic [LEN_W-1:0]   lb_derived;
  logic [LEN_W-1:0]   lb_sel;
  logic [LEN_W-1:0]   lb;
  logic               line_end;
  logic               lastrow;
  logic               big;
  logic [3:0]         nib_first;
  logic [3:0]         nib_second;
  logic [31:0]        acc;
  logic [RCNT_W-1:0]  n;
  rec_t               rec;
  logic               accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = push_ready;
  assign push     = accept && (rec.cnt != '0);
  assign push_rec = rec;

  // Geometry and container size from the registers.
  always_comb begin
    is4       = (pixel_depth == DEPTH_W'(4));
    bad_depth = (pixel_depth == '0) || (pixel_depth > DEPTH_W'(32));
    nbm1      = 2'((pixel_depth - DEPTH_W'(1)) >> 3);
    for (int i = 0; i < 32; i++) begin
      mask[i] = (DEPTH_W'(i) < pixel_depth);
    end
    if (image_width == '0) begin
      wc = COL_W'(1);
    end else if (32'(image_width) > 32'(WIDTH_MAX)) begin
      wc = COL_W'(WIDTH_MAX);
    end else begin
      wc = COL_W'(image_width);
    end
    if (image_height == '0) begin
      hc = ROW_W'(1);
    end else if (32'(image_height) > 32'(HEIGHT_MAX)) begin
      hc = ROW_W'(HEIGHT_MAX);
    end else begin
      hc = ROW_W'(image_height);
    end
    wl = LEN_W'(wc);
    if (is4) begin
      lb_derived = (wl + LEN_W'(1)) >> 1;
    end else begin
      case (nbm1)
        2'd0:    lb_derived = wl;
        2'd1:    lb_derived = wl << 1;
        2'd2:    lb_derived = (wl << 1) + wl;
        default: lb_derived = wl << 2;
      endcase
    end
    lb_sel   = (line_bytes != '0) ? LEN_W'(line_bytes) : lb_derived;
    lb       = (lb_sel > LEN_W'(LINE_BYTES_MAX)) ? LEN_W'(LINE_BYTES_MAX) : lb_sel;
    line_end = (LEN_W'(line_byte_count) + LEN_W'(1)) >= lb;
    lastrow  = ((ROW_W + 1)'(row_count) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(hc);
  end

  // Byte assembly and the list of results for this byte.
  always_comb begin
    big        = data_msb_first ^ ~header_msb;
    nib_first  = data_msb_first ? data_byte[7:4] : data_byte[3:0];
    nib_second = data_msb_first ? data_byte[3:0] : data_byte[7:4];
    if (big) begin
      acc = {partial_pixel, data_byte};
    end else begin
      acc = 32'(partial_pixel) | (32'(data_byte) << {byte_in_pixel, 3'b000});
    end

    rec                  = '0;
    n                    = '0;
    pixel_column_next    = pixel_column;
    partial_pixel_next   = partial_pixel;
    byte_in_pixel_next   = byte_in_pixel;
    line_byte_count_next = line_byte_count;
    row_count_next       = row_count;

    if (bad_depth) begin
      rec.res[0].status = ST_BAD_DEPTH;
      n = RCNT_W'(1);
    end else begin
      if (is4) begin
        if (pixel_column_next < wc) begin
          rec.res[n].value      = 32'(nib_first) & mask;
          rec.res[n].status     = ST_PIXEL;
          rec.res[n].last_line  = ((COL_W + 1)'(pixel_column_next) + (COL_W + 1)'(1))
                                  == (COL_W + 1)'(wc);
          rec.res[n].last_image = rec.res[n].last_line && lastrow;
          n = n + RCNT_W'(1);
          pixel_column_next = pixel_column_next + COL_W'(1);
        end
        if (pixel_column_next < wc) begin
          rec.res[n].value      = 32'(nib_second) & mask;
          rec.res[n].status     = ST_PIXEL;
          rec.res[n].last_line  = ((COL_W + 1)'(pixel_column_next) + (COL_W + 1)'(1))
                                  == (COL_W + 1)'(wc);
          rec.res[n].last_image = rec.res[n].last_line && lastrow;
          n = n + RCNT_W'(1);
          pixel_column_next = pixel_column_next + COL_W'(1);
        end
      end else if (pixel_column < wc) begin
        if (byte_in_pixel >= nbm1) begin
          rec.res[n].value      = acc & mask;
          rec.res[n].status     = ST_PIXEL;
          rec.res[n].last_line  = ((COL_W + 1)'(pixel_column) + (COL_W + 1)'(1))
                                  == (COL_W + 1)'(wc);
          rec.res[n].last_image = rec.res[n].last_line && lastrow;
          n = n + RCNT_W'(1);
          pixel_column_next  = pixel_column + COL_W'(1);
          partial_pixel_next = '0;
          byte_in_pixel_next = '0;
        end else begin
          partial_pixel_next = acc[23:0];
          byte_in_pixel_next = byte_in_pixel + 2'd1;
        end
      end

      if (line_end) begin
        // The line ran out of bytes before its last pixel: flag it.
        if (pixel_column_next < wc) begin
          rec.res[n].status     = ST_SHORT_LINE;
          rec.res[n].last_line  = 1'b1;
          rec.res[n].last_image = lastrow;
          n = n + RCNT_W'(1);
        end
        pixel_column_next    = '0;
        partial_pixel_next   = '0;
        byte_in_pixel_next   = '0;
        line_byte_count_next = '0;
        row_count_next       = lastrow ? '0 : row_count + ROW_W'(1);
      end else begin
        line_byte_count_next = line_byte_count + LBC_W'(1);
      end
    end
    rec.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_depth     <= DEPTH_W'(8);
      data_msb_first  <= 1'b1;
      header_msb      <= 1'b1;
      image_width     <= SIZE_W'(1);
      image_height    <= SIZE_W'(1);
      line_bytes      <= '0;
      partial_pixel   <= '0;
      byte_in_pixel   <= '0;
      pixel_column    <= '0;
      line_byte_count <= '0;
      row_count       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PIXEL_DEPTH:    pixel_depth    <= cfg_data[DEPTH_W-1:0];
          REG_DATA_MSB_FIRST: data_msb_first <= cfg_data[0];
          REG_HEADER_MSB:     header_msb     <= cfg_data[0];
          REG_IMAGE_WIDTH:    image_width    <= cfg_data[SIZE_W-1:0];
          REG_IMAGE_HEIGHT:   image_height   <= cfg_data[SIZE_W-1:0];
          REG_LINE_BYTES:     line_bytes     <= cfg_data[LB_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        partial_pixel   <= partial_pixel_next;
        byte_in_pixel   <= byte_in_pixel_next;
        pixel_column    <= pixel_column_next;
        line_byte_count <= line_byte_count_next;
        row_count       <= row_count_next;
      end
    end
  end

endmodule

### rtl/zsu_queue.sv
// Short register queue of per-byte result records between front and back.
// Depends on zsu_pkg.
`include "assert_macros.svh"
module zsu_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  zsu_pkg::rec_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output zsu_pkg::rec_t rd_data
);
  import zsu_pkg::*;

  rec_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk, rst, wr_valid && !wr_ready)
  `ASSERT_NEVER(a_no_underflow, clk, rst, rd_ready && !rd_valid)
  `ASSERT_NEVER(a_count_bound, clk, rst, count > QCNT_W'(QUEUE_DEPTH))

endmodule

### rtl/zsu_back.sv
// Back end: walks the results of each queued record and delivers them one
// at a time through an output register. Depends on zsu_pkg.
`include "assert_macros.svh"
module zsu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_valid,
  output logic          rd_ready,
  input  zsu_pkg::rec_t rd_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   pixel_value,
  output logic [1:0]    status,
  output logic          last_in_line,
  output logic          last_in_image
);
  import zsu_pkg::*;

  logic [RCNT_W-1:0] idx;
  logic              load;
  logic              rec_done;
  res_t              res_q;

  // The output register refills in the same cycle it is emptied.
  assign load     = rd_valid && (!out_valid || out_ready);
  assign rec_done = (idx + RCNT_W'(1)) == rd_data.cnt;
  assign rd_ready = load && rec_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= rec_done ? '0 : idx + RCNT_W'(1);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= rd_data.res[idx];
    end
  end

  assign pixel_value   = res_q.value;
  assign status        = res_q.status;
  assign last_in_line  = res_q.last_line;
  assign last_in_image = res_q.last_image;

  `ASSERT_IMPLY(a_rec_nonempty, clk, rst, rd_valid, rd_data.cnt != '0)
  `ASSERT_IMPLY(a_idx_in_rec, clk, rst, rd_valid, idx < rd_data.cnt)
  `ASSERT_IMPLY(a_idx_rest, clk, rst, !rd_valid, idx == '0)

endmodule

### rtl/zpixmap_scanline_unpack.sv
// ZPixmap scan line unpacker: image bytes in, masked pixels out.
// Depends on zsu_pkg, zsu_front, zsu_queue and zsu_back.
//
// Input channel: one data byte per item on in_valid/in_ready. Output channel:
// one result per item on out_valid/out_ready carrying pixel_value, status,
// last_in_line and last_in_image. Configuration: cfg_we writes cfg_data into
// the register selected by cfg_index; write only while idle. A byte gives
// zero to three results: padding bytes give none, 4-bit pixels give up to
// two per byte, and the byte that ends a short line adds a status item.
// A byte's first result passes through the record queue and then the output
// register. Throughput: one byte per cycle while each byte yields at most
// one result and the receiver does not stall; the output register delivers
// one result per cycle while out_ready is high, so bytes with two or three
// results fall behind on the output side, and a four-entry record queue
// absorbs the difference before in_ready drops.
// Reset loads the register defaults (depth 8, MSB first, 1x1 image, derived
// line length), clears line and pixel position and empties the queue.
// When the receiver stalls, the output holds, the queue fills, and then
// in_ready goes low until room frees up.
module zpixmap_scanline_unpack (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [zsu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [zsu_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     data_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [31:0]                    pixel_value,
  output logic [1:0]                     status,
  output logic                           last_in_line,
  output logic                           last_in_image
);
  import zsu_pkg::*;

  logic push;
  logic push_ready;
  rec_t push_rec;
  logic q_valid;
  logic q_ready;
  rec_t q_rec;

  zsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .push       (push),
    .push_rec   (push_rec),
    .push_ready (push_ready)
  );

  zsu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push),
    .wr_ready (push_ready),
    .wr_data  (push_rec),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_rec)
  );

  zsu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .rd_valid      (q_valid),
    .rd_ready      (q_ready),
    .rd_data       (q_rec),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_value   (pixel_value),
    .status        (status),
    .last_in_line  (last_in_line),
    .last_in_image (last_in_image)
  );

endmodule
